// ===== hw/rtl/fdf_pkg.sv =====
`default_nettype none

package fdf_pkg;

   // window length and field widths
   localparam int TAPS   = 100;
   localparam int SMP_W  = 32;
   localparam int WT_W   = 32;
   localparam int ORD_W  = 15;
   localparam int OUT_W  = 48;
   localparam int FRAC_W = 14;
   localparam int WT_FRAC = 28;

   // counters
   localparam int CNT_W  = $clog2(TAPS);
   localparam int SEEN_W = $clog2(TAPS + 1);

   // filter datapath
   localparam int PROD_W = SMP_W + WT_W;
   localparam int ACC_W  = PROD_W + $clog2(TAPS);
   localparam int RND_W  = ACC_W - WT_FRAC;

   // weight recursion datapath
   localparam int FACT_W = CNT_W + FRAC_W + 1;
   localparam int NUM_W  = WT_W + FACT_W;
   localparam int QW     = NUM_W - FRAC_W + 1;
   localparam int DIG_B  = 4;
   localparam int DIG_N  = (QW + DIG_B - 1) / DIG_B;
   localparam int QWP    = DIG_N * DIG_B;
   localparam int DIG_W  = (DIG_N > 1) ? $clog2(DIG_N) : 1;

   typedef logic signed [SMP_W-1:0]  smp_type;
   typedef logic signed [WT_W-1:0]   wt_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [ACC_W-1:0]  acc_type;
   typedef logic signed [OUT_W-1:0]  out_type;
   typedef logic signed [RND_W-1:0]  rnd_type;
   typedef logic signed [FACT_W-1:0] fact_type;
   typedef logic signed [NUM_W-1:0]  num_type;
   typedef logic [QWP-1:0]           quo_type;
   typedef logic [ORD_W-1:0]         ord_type;

   localparam wt_type  ONE_WT   = wt_type'(1) <<< WT_FRAC;
   localparam wt_type  WT_MAX   = 32'sh7FFF_FFFF;
   localparam wt_type  WT_MIN   = 32'sh8000_0000;
   localparam acc_type RND_HALF = acc_type'(1) <<< (WT_FRAC - 1);

   // control shared by every cell of the chain
   typedef struct packed {
      logic hist_shift;
      logic wt_shift;
      logic prod_en;
      logic acc_en;
      logic acc_first;
   } cell_ctl_type;

   // weight generator status toward the top level
   typedef struct packed {
      logic busy;
      logic wt_push;
      logic replay_step;
      logic replay_first;
   } wgen_stat_type;

   typedef enum logic [2:0] {
      WG_IDLE,
      WG_PUSH,
      WG_MUL,
      WG_PREP,
      WG_DIV,
      WG_REPLAY
   } wgen_state_type;

endpackage

`default_nettype wire

// ===== hw/rtl/fdf_cell.sv =====
`default_nettype none

module fdf_cell (
   input  wire logic                 clock,
   input  wire fdf_pkg::cell_ctl_type ctl,
   input  wire fdf_pkg::smp_type      x_bcast,
   input  wire fdf_pkg::smp_type      hist_left,
   input  wire fdf_pkg::wt_type       wt_right,
   input  wire fdf_pkg::acc_type      acc_right,
   output fdf_pkg::smp_type           hist_out,
   output fdf_pkg::wt_type            wt_out,
   output fdf_pkg::acc_type           acc_out
);

   fdf_pkg::smp_type  hist_ff;
   fdf_pkg::wt_type   wt_ff;
   fdf_pkg::prod_type prod_ff;
   fdf_pkg::prod_type prod_in;
   fdf_pkg::acc_type  acc_ff;
   fdf_pkg::acc_type  acc_in;

   // tap product, then partial sum handed toward cell zero
   always_comb begin
      prod_in = fdf_pkg::prod_type'(x_bcast) * fdf_pkg::prod_type'(wt_ff);
      acc_in  = (ctl.acc_first ? '0 : acc_right) + fdf_pkg::acc_type'(prod_ff);
   end

   always_ff @(posedge clock) begin
      if (ctl.hist_shift) begin
         hist_ff <= hist_left;
      end
      if (ctl.wt_shift) begin
         wt_ff <= wt_right;
      end
      if (ctl.prod_en) begin
         prod_ff <= prod_in;
      end
      if (ctl.acc_en) begin
         acc_ff <= acc_in;
      end
   end

   assign hist_out = hist_ff;
   assign wt_out   = wt_ff;
   assign acc_out  = acc_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/fdf_wgen.sv =====
`default_nettype none

module fdf_wgen (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  adv,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire fdf_pkg::ord_type      csr_diff_order,
   output fdf_pkg::wgen_stat_type     stat,
   output fdf_pkg::wt_type            wt_new
);

   typedef logic [fdf_pkg::NUM_W:0]   rnd_sum_type;
   typedef logic [fdf_pkg::NUM_W-1:0] mag_type;

   fdf_pkg::wgen_state_type state_ff, state_in;
   logic [fdf_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic [fdf_pkg::DIG_W-1:0] dig_ff, dig_in;
   fdf_pkg::ord_type          d_ff, d_in;
   fdf_pkg::wt_type           wprev_ff, wprev_in;
   fdf_pkg::num_type          num_ff, num_in;
   logic                      neg_ff, neg_in;
   fdf_pkg::quo_type          quo_ff, quo_in;
   logic [fdf_pkg::CNT_W-1:0] rem_ff, rem_in;

   logic [fdf_pkg::CNT_W-1:0] km1;
   fdf_pkg::fact_type         fact;
   mag_type                   mag;
   rnd_sum_type               rnd_sum;
   fdf_pkg::quo_type          quo_step;
   logic [fdf_pkg::CNT_W-1:0] rem_step;
   fdf_pkg::wt_type           wt_sat;
   logic                      sat_hi;

   // factor (d - (k-1)) in q14, k taken from the counter
   always_comb begin
      km1  = cnt_ff - fdf_pkg::CNT_W'(1);
      fact = fdf_pkg::fact_type'({1'b0, d_ff})
           - fdf_pkg::fact_type'({1'b0, km1, {fdf_pkg::FRAC_W{1'b0}}});
   end

   // magnitude, half-divisor rounding and the 2^14 part of the divisor
   always_comb begin
      mag     = num_ff[fdf_pkg::NUM_W-1] ? mag_type'(-num_ff) : mag_type'(num_ff);
      rnd_sum = {1'b0, mag}
              + rnd_sum_type'({cnt_ff, {(fdf_pkg::FRAC_W-1){1'b0}}});
   end

   // four restoring division steps by k per cycle
   always_comb begin
      logic [fdf_pkg::CNT_W:0] r;
      logic                    qb;
      r        = {1'b0, rem_ff};
      quo_step = quo_ff;
      for (int i = 0; i < fdf_pkg::DIG_B; i++) begin
         r = {r[fdf_pkg::CNT_W-1:0], quo_step[fdf_pkg::QWP-1]};
         if (r >= {1'b0, cnt_ff}) begin
            r  = r - {1'b0, cnt_ff};
            qb = 1'b1;
         end else begin
            qb = 1'b0;
         end
         quo_step = {quo_step[fdf_pkg::QWP-2:0], qb};
      end
      rem_step = r[fdf_pkg::CNT_W-1:0];
   end

   // negate and saturate the quotient to a q4.28 weight
   always_comb begin
      if (neg_ff) begin
         sat_hi = (|quo_ff[fdf_pkg::QWP-1:32]) || (quo_ff[31] && (|quo_ff[30:0]));
         wt_sat = sat_hi ? fdf_pkg::WT_MIN : fdf_pkg::wt_type'(-quo_ff[31:0]);
      end else begin
         sat_hi = |quo_ff[fdf_pkg::QWP-1:31];
         wt_sat = sat_hi ? fdf_pkg::WT_MAX : fdf_pkg::wt_type'(quo_ff[31:0]);
      end
   end

   assign wt_new = (cnt_ff == '0) ? fdf_pkg::ONE_WT : wt_sat;

   // sequencer: build, push into the chain, then replay history
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      dig_in    = dig_ff;
      d_in      = d_ff;
      wprev_in  = wprev_ff;
      num_in    = num_ff;
      neg_in    = neg_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      csr_ready = 1'b0;
      stat      = '0;
      stat.busy = (state_ff != fdf_pkg::WG_IDLE);
      unique case (state_ff)
         fdf_pkg::WG_IDLE: begin
            csr_ready = 1'b1;
            if (csr_valid) begin
               d_in     = csr_diff_order;
               cnt_in   = '0;
               state_in = fdf_pkg::WG_PUSH;
            end
         end
         fdf_pkg::WG_PUSH: begin
            stat.wt_push = 1'b1;
            wprev_in     = wt_new;
            if (cnt_ff == fdf_pkg::CNT_W'(fdf_pkg::TAPS - 1)) begin
               cnt_in   = '0;
               state_in = fdf_pkg::WG_REPLAY;
            end else begin
               cnt_in   = cnt_ff + fdf_pkg::CNT_W'(1);
               state_in = fdf_pkg::WG_MUL;
            end
         end
         fdf_pkg::WG_MUL: begin
            num_in   = fdf_pkg::num_type'(wprev_ff) * fdf_pkg::num_type'(fact);
            state_in = fdf_pkg::WG_PREP;
         end
         fdf_pkg::WG_PREP: begin
            neg_in   = !num_ff[fdf_pkg::NUM_W-1] && (num_ff != '0);
            quo_in   = fdf_pkg::quo_type'(rnd_sum[fdf_pkg::NUM_W:fdf_pkg::FRAC_W]);
            rem_in   = '0;
            dig_in   = '0;
            state_in = fdf_pkg::WG_DIV;
         end
         fdf_pkg::WG_DIV: begin
            quo_in = quo_step;
            rem_in = rem_step;
            dig_in = dig_ff + fdf_pkg::DIG_W'(1);
            if (dig_ff == fdf_pkg::DIG_W'(fdf_pkg::DIG_N - 1)) begin
               state_in = fdf_pkg::WG_PUSH;
            end
         end
         fdf_pkg::WG_REPLAY: begin
            if (adv) begin
               stat.replay_step  = 1'b1;
               stat.replay_first = (cnt_ff == '0);
               if (cnt_ff == fdf_pkg::CNT_W'(fdf_pkg::TAPS - 1)) begin
                  cnt_in   = '0;
                  state_in = fdf_pkg::WG_IDLE;
               end else begin
                  cnt_in = cnt_ff + fdf_pkg::CNT_W'(1);
               end
            end
         end
         default: begin
            state_in = fdf_pkg::WG_IDLE;
         end
      endcase
   end

   // control registers; reset starts a build with order zero
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fdf_pkg::WG_PUSH;
         cnt_ff   <= '0;
         dig_ff   <= '0;
         d_ff     <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         dig_ff   <= dig_in;
         d_ff     <= d_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      wprev_ff <= wprev_in;
      num_ff   <= num_in;
      neg_ff   <= neg_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
   end

endmodule

`default_nettype wire

// ===== hw/rtl/fractional_difference_fir.sv =====
`default_nettype none

// channel  | ports                                   | direction
// ---------+-----------------------------------------+-----------
// req      | req_valid, req_stall, req_sample        | sample in
// rsp      | rsp_valid, rsp_stall, rsp_diff_value,   | result out
//          | rsp_valid_res                           |
// csr      | csr_valid, csr_ready, csr_diff_order    | order write
//
// one sample per cycle while req_stall is low, through a transposed chain
// of TAPS cells; a result passes the x, product, partial sum, output regs.
// reset and each diff_order write rebuild the weights with a 4-bit-per-cycle
// serial divider, then replay the held history through the chain; req_stall
// is high for that whole time.
// rsp_stall with a full output register freezes all stages and stalls req.

module fractional_difference_fir (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire fdf_pkg::smp_type     req_sample,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output fdf_pkg::out_type          rsp_diff_value,
   output logic                      rsp_valid_res,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire fdf_pkg::ord_type     csr_diff_order
);

   typedef struct packed {
      logic vld;
      logic live;
      logic vres;
      logic first;
   } tok_type;

   fdf_pkg::wgen_stat_type stat;
   fdf_pkg::wt_type        wt_new;
   fdf_pkg::cell_ctl_type  ctl;

   logic                   advance;
   logic                   accept;
   logic                   step;
   fdf_pkg::smp_type       x_sel;

   fdf_pkg::smp_type       x_ff;
   tok_type                tok_a_ff, tok_a_in;
   tok_type                tok_b_ff;
   tok_type                tok_c_ff;
   logic [fdf_pkg::SEEN_W-1:0] seen_ff, seen_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   fdf_pkg::out_type       val_ff, val_in;
   logic                   vres_ff;

   fdf_pkg::acc_type       rnd_sum;
   fdf_pkg::rnd_type       rnd_q;

   fdf_pkg::smp_type       hist_w [fdf_pkg::TAPS];
   fdf_pkg::wt_type        wt_w   [fdf_pkg::TAPS];
   fdf_pkg::acc_type       acc_w  [fdf_pkg::TAPS];

   // weight builder and history replay sequencer
   fdf_wgen u_wgen (
      .clock          (clock),
      .reset          (reset),
      .adv            (advance),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_diff_order (csr_diff_order),
      .stat           (stat),
      .wt_new         (wt_new)
   );

   // handshake and stage control
   always_comb begin
      advance   = !rsp_valid_ff || !rsp_stall;
      req_stall = stat.busy || !advance;
      accept    = req_valid && !req_stall;
      step      = accept || stat.replay_step;
      x_sel     = stat.replay_step ? hist_w[fdf_pkg::TAPS-1] : req_sample;

      ctl.hist_shift = step;
      ctl.wt_shift   = stat.wt_push;
      ctl.prod_en    = advance;
      ctl.acc_en     = advance && tok_b_ff.vld;
      ctl.acc_first  = tok_b_ff.first;

      tok_a_in.vld   = step;
      tok_a_in.live  = accept;
      tok_a_in.vres  = accept && (seen_ff >= fdf_pkg::SEEN_W'(fdf_pkg::TAPS));
      tok_a_in.first = stat.replay_first;

      seen_in = seen_ff;
      if (accept && (seen_ff < fdf_pkg::SEEN_W'(fdf_pkg::TAPS))) begin
         seen_in = seen_ff + fdf_pkg::SEEN_W'(1);
      end
   end

   // chain of tap cells, history enters at cell zero, weights at the far end
   for (genvar i = 0; i < fdf_pkg::TAPS; i++) begin : g_cell
      fdf_pkg::smp_type hist_left;
      fdf_pkg::wt_type  wt_right;
      fdf_pkg::acc_type acc_right;

      if (i == 0) begin : g_head
         assign hist_left = x_sel;
      end else begin : g_body
         assign hist_left = hist_w[i-1];
      end

      if (i == fdf_pkg::TAPS - 1) begin : g_tail
         assign wt_right  = wt_new;
         assign acc_right = '0;
      end else begin : g_mid
         assign wt_right  = wt_w[i+1];
         assign acc_right = acc_w[i+1];
      end

      fdf_cell u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .x_bcast   (x_ff),
         .hist_left (hist_left),
         .wt_right  (wt_right),
         .acc_right (acc_right),
         .hist_out  (hist_w[i]),
         .wt_out    (wt_w[i]),
         .acc_out   (acc_w[i])
      );
   end

   // round the q27.44 sum to q32.16, ties upward; it always fits 48 bits
   always_comb begin
      rnd_sum      = acc_w[0] + fdf_pkg::RND_HALF;
      rnd_q        = rnd_sum[fdf_pkg::ACC_W-1:fdf_pkg::WT_FRAC];
      val_in       = tok_c_ff.vres ? fdf_pkg::out_type'(rnd_q) : '0;
      rsp_valid_in = tok_c_ff.vld && tok_c_ff.live;
   end

   // pipeline control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_a_ff     <= '0;
         tok_b_ff     <= '0;
         tok_c_ff     <= '0;
         seen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seen_ff <= seen_in;
         if (advance) begin
            tok_a_ff     <= tok_a_in;
            tok_b_ff     <= tok_a_ff;
            tok_c_ff     <= tok_b_ff;
            rsp_valid_ff <= rsp_valid_in;
         end
      end
   end

   // sample broadcast and result payload
   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff <= x_sel;
      end
      if (advance && rsp_valid_in) begin
         val_ff  <= val_in;
         vres_ff <= tok_c_ff.vres;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_diff_value = val_ff;
   assign rsp_valid_res  = vres_ff;

endmodule

`default_nettype wire
